// ===== src/cpfm_pkg.sv =====
`timescale 1ns / 1ps

package cpfm_pkg;

	// Field widths
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W  = 5;

	// Core clock after reset, in Hz
	localparam logic [WORD_W-1:0] CORE_CLOCK_RESET = 32'd168000000;

	// Last step of the radix-2 divider
	localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== src/capture_pair_frequency_meter_top.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake              | Payload
// ---------+------------------------+--------------------------------------------
// capture  | in_valid / in_stall    | capture_value[31:0]
// result   | out_valid / out_stall  | frequency_hz[31:0], period_ticks[31:0],
//          |                        | zero_period
// config   | cfg_valid / cfg_ready  | cfg_data[31:0] (core clock in Hz)
//
// The first capture of a pair is taken and gives no result.
// The second is taken in ST_IDLE, then runs 32 steps of the restoring
// subtract-and-shift divider in ST_DIV, then loads the result register in
// ST_DONE once the output is free. An equal pair skips the divider.
// Reset (arst_n low) waits for a first capture, core clock 168 MHz.
// A held result stalls the block only when the next result is ready to load.

module capture_pair_frequency_meter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cpfm_pkg::WORD_W-1:0]   capture_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cpfm_pkg::WORD_W-1:0]   frequency_hz,
	output logic [cpfm_pkg::WORD_W-1:0]   period_ticks,
	output logic                          zero_period,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cpfm_pkg::WORD_W-1:0]   cfg_data
);

	import cpfm_pkg::*;

	state_t              state_q, state_d;
	logic [WORD_W-1:0]   core_clock_q;
	logic                have_first_q;
	logic [WORD_W-1:0]   first_q;
	logic [WORD_W-1:0]   period_q;
	logic [WORD_W-1:0]   rem_q;
	logic [WORD_W-1:0]   quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                zero_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   freq_out_q;
	logic [WORD_W-1:0]   period_out_q;
	logic                zero_out_q;

	logic                in_take;
	logic                out_free;
	logic                load_out;
	logic [WORD_W-1:0]   period_new;
	logic [WORD_W:0]     shifted;
	logic [WORD_W+1:0]   trial;

	// Handshakes
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = (state_q == ST_IDLE);

	// Modular difference of the pair
	assign period_new = capture_value - first_q;

	// One restoring divider step
	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, period_q};

	// Sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && have_first_q) begin
					state_d = (period_new == '0) ? ST_DONE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			have_first_q <= 1'b0;
			first_q      <= '0;
			core_clock_q <= CORE_CLOCK_RESET;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				core_clock_q <= cfg_data;
			end
			if (in_take) begin
				have_first_q <= !have_first_q;
				if (!have_first_q) begin
					first_q <= capture_value;
				end
			end
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Divider datapath: dividend shifts out of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (in_take && have_first_q) begin
			period_q <= period_new;
			zero_q   <= (period_new == '0);
			rem_q    <= '0;
			quo_q    <= {1'b0, core_clock_q[WORD_W-1:1]};
		end else if (state_q == ST_DIV) begin
			if (!trial[WORD_W+1]) begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			freq_out_q   <= zero_q ? '0 : quo_q + 1'b1;
			period_out_q <= period_q;
			zero_out_q   <= zero_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign frequency_hz = freq_out_q;
	assign period_ticks = period_out_q;
	assign zero_period  = zero_out_q;

	// Checks
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_period |-> frequency_hz == '0 && period_ticks == '0)
		else $error("zero period result carries nonzero fields");

	a_nonzero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_period |-> frequency_hz != '0)
		else $error("nonzero period gave zero frequency");

	a_second_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && have_first_q |=> state_q == ST_DIV || state_q == ST_DONE)
		else $error("second capture did not start the divider");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DIV |-> cnt_q == '0)
		else $error("divider step count running outside divide");

endmodule

// ===== bench/tb_capture_pair_frequency_meter_top.sv =====
`timescale 1ns / 1ps

module tb_capture_pair_frequency_meter_top;
	import cpfm_pkg::*;

	typedef logic [WORD_W-1:0] word_t;

	// One frequency reading as the block presents it
	typedef struct packed {
		word_t freq;
		word_t period;
		logic  zero;
	} reading_t;

	typedef enum logic {
		ROW_CAPTURE,
		ROW_CLOCK
	} row_kind_t;

	// Directed row: a capture beat or a core clock write, with an optional typed reading
	typedef struct packed {
		row_kind_t kind;
		word_t     value;
		logic      typed;
		reading_t  reading;
	} directed_row_t;

	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned PHASES         = 10;
	localparam int unsigned CAPS_PER_PHASE = 145;

	logic  clk         = 1'b0;
	logic  arst_n      = 1'b0;
	logic  in_valid    = 1'b0;
	logic  in_stall;
	word_t capture_value = '0;
	logic  out_valid;
	logic  out_stall   = 1'b0;
	word_t frequency_hz;
	word_t period_ticks;
	logic  zero_period;
	logic  cfg_valid   = 1'b0;
	logic  cfg_ready;
	word_t cfg_data    = '0;

	// Predictor state
	word_t clock_hz   = CORE_CLOCK_RESET;
	bit    pair_open  = 1'b0;
	word_t pair_start = '0;

	reading_t    expected_readings[$];
	int unsigned mismatches    = 0;
	bit          sender_calm   = 1'b0;
	bit          receiver_calm = 1'b0;

	capture_pair_frequency_meter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.capture_value(capture_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frequency_hz (frequency_hz),
		.period_ticks (period_ticks),
		.zero_period  (zero_period),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Safety net
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	// Pair the captures and work out the reading a closing capture gives
	function void predict_reading(input word_t cap, output bit produced, output reading_t r);
		r = '0;
		produced = 1'b0;
		if (!pair_open) begin
			pair_start = cap;
			pair_open = 1'b1;
		end else begin
			r.period = cap - pair_start;
			if (r.period == '0) begin
				r.freq = '0;
				r.zero = 1'b1;
			end else begin
				r.freq = (clock_hz >> 1) / r.period + 1;
				r.zero = 1'b0;
			end
			pair_open = 1'b0;
			produced = 1'b1;
		end
	endfunction

	// Offer one capture beat, log its reading once taken, then sometimes pause the sender
	task send_capture(input word_t cap, input bit typed, input reading_t typed_reading);
		bit       produced;
		reading_t r;
		int       gap;
		@(negedge clk) begin
			in_valid <= 1'b1;
			capture_value <= cap;
		end
		do @(posedge clk); while (in_stall);
		predict_reading(cap, produced, r);
		if (produced)
			expected_readings.push_back(typed ? typed_reading : r);
		if ($urandom_range(0, 39) == 0)
			sender_calm = !sender_calm;
		gap = sender_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			@(negedge clk) begin
				in_valid <= 1'b0;
				capture_value <= $urandom;
			end
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Let the block drain fully before anything else happens
	task drain_to_idle();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Core clock write, only with the block idle
	task write_core_clock(input word_t hz);
		drain_to_idle();
		@(negedge clk) begin
			cfg_valid <= 1'b1;
			cfg_data <= hz;
		end
		do @(posedge clk); while (!cfg_ready);
		clock_hz = hz;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Random pair: mostly well-formed with a spread of periods
	task send_random_pair();
		word_t first;
		word_t period;
		word_t quot;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: first = '0;
				1: first = '1;
				2: first = 32'h8000_0000;
				default: first = 32'h7FFF_FFFF;
			endcase
		end else begin
			first = $urandom;
		end
		case ($urandom_range(0, 9))
			0: period = '0;
			1, 2, 3: period = $urandom_range(1, 64);
			4: period = '1 - $urandom_range(0, 64);
			5: begin
				// around an exact division of the half clock
				quot = (clock_hz >> 1) / $urandom_range(1, 2000);
				period = quot + $urandom_range(0, 2) - 1;
			end
			default: period = $urandom;
		endcase
		send_capture(first, 1'b0, '0);
		send_capture(first + period, 1'b0, '0);
	endtask

	// Result side: random stall, then check each beat against the oldest reading
	initial begin
		int       gap;
		reading_t exp_r;
		forever begin
			if ($urandom_range(0, 39) == 0)
				receiver_calm = !receiver_calm;
			gap = receiver_calm ? 0 : $urandom_range(0, 19);
			if (gap == 0) begin
				@(negedge clk) out_stall <= 1'b0;
			end else begin
				@(negedge clk) out_stall <= 1'b1;
				while (!out_valid) @(negedge clk);
				repeat (gap) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			if (expected_readings.size() == 0) begin
				$error("unexpected result beat: freq %0h period %0h zero %0b",
					frequency_hz, period_ticks, zero_period);
				mismatches++;
			end else begin
				exp_r = expected_readings.pop_front();
				if (frequency_hz !== exp_r.freq) begin
					$error("frequency_hz: expected %0h, got %0h", exp_r.freq, frequency_hz);
					mismatches++;
				end
				if (period_ticks !== exp_r.period) begin
					$error("period_ticks: expected %0h, got %0h", exp_r.period, period_ticks);
					mismatches++;
				end
				if (zero_period !== exp_r.zero) begin
					$error("zero_period: expected %0b, got %0b", exp_r.zero, zero_period);
					mismatches++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		directed_row_t directed_rows[25];
		word_t         phase_hz;
		int unsigned   sent;

		directed_rows = '{
			// equal pair at zero
			'{ROW_CAPTURE, 32'h0000_0000, 1'b0, '0},
			'{ROW_CAPTURE, 32'h0000_0000, 1'b1, '{32'd0, 32'd0, 1'b1}},
			// longest period
			'{ROW_CAPTURE, 32'h0000_0000, 1'b0, '0},
			'{ROW_CAPTURE, 32'hFFFF_FFFF, 1'b1, '{32'd1, 32'hFFFF_FFFF, 1'b0}},
			// counter wrap, shortest period
			'{ROW_CAPTURE, 32'hFFFF_FFFF, 1'b0, '0},
			'{ROW_CAPTURE, 32'h0000_0000, 1'b1, '{32'd84000001, 32'd1, 1'b0}},
			// wrap across a few ticks
			'{ROW_CAPTURE, 32'hFFFF_FFF0, 1'b0, '0},
			'{ROW_CAPTURE, 32'h0000_0010, 1'b1, '{32'd2625001, 32'd32, 1'b0}},
			// equal pair at all ones
			'{ROW_CAPTURE, 32'hFFFF_FFFF, 1'b0, '0},
			'{ROW_CAPTURE, 32'hFFFF_FFFF, 1'b1, '{32'd0, 32'd0, 1'b1}},
			// fastest clock
			'{ROW_CLOCK,   32'hFFFF_FFFF, 1'b0, '0},
			'{ROW_CAPTURE, 32'h1234_5678, 1'b0, '0},
			'{ROW_CAPTURE, 32'h1234_5679, 1'b1, '{32'h8000_0000, 32'd1, 1'b0}},
			'{ROW_CAPTURE, 32'hAAAA_AAAA, 1'b0, '0},
			'{ROW_CAPTURE, 32'h5555_5555, 1'b0, '0},
			// slowest clock
			'{ROW_CLOCK,   32'd2,         1'b0, '0},
			'{ROW_CAPTURE, 32'h0000_0000, 1'b0, '0},
			'{ROW_CAPTURE, 32'h0000_0001, 1'b1, '{32'd2, 32'd1, 1'b0}},
			'{ROW_CAPTURE, 32'h8000_0000, 1'b0, '0},
			'{ROW_CAPTURE, 32'h7FFF_FFFF, 1'b1, '{32'd1, 32'hFFFF_FFFF, 1'b0}},
			'{ROW_CAPTURE, 32'h0000_0005, 1'b0, '0},
			'{ROW_CAPTURE, 32'h0000_0005, 1'b1, '{32'd0, 32'd0, 1'b1}},
			// back to the reset clock, exact division
			'{ROW_CLOCK,   CORE_CLOCK_RESET, 1'b0, '0},
			'{ROW_CAPTURE, 32'h0000_0000, 1'b0, '0},
			'{ROW_CAPTURE, 32'd84000000,  1'b1, '{32'd2, 32'd84000000, 1'b0}}
		};

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CLOCK)
				write_core_clock(directed_rows[i].value);
			else
				send_capture(directed_rows[i].value, directed_rows[i].typed,
					directed_rows[i].reading);
		end

		// Random phases, each under its own core clock
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: phase_hz = 32'd2;
				1: phase_hz = 32'hFFFF_FFFF;
				2: phase_hz = 32'hFFFF_FFFE;
				3: phase_hz = CORE_CLOCK_RESET;
				4: phase_hz = $urandom_range(1000, 2);
				default: phase_hz = $urandom_range(32'hFFFF_FFFF, 2);
			endcase
			write_core_clock(phase_hz);
			sent = 0;
			while (sent < CAPS_PER_PHASE) begin
				// a lone capture now and then shifts the pairing
				if ($urandom_range(0, 19) == 0) begin
					send_capture($urandom, 1'b0, '0);
					sent += 1;
				end else begin
					send_random_pair();
					sent += 2;
				end
			end
		end

		drain_to_idle();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
